// ===== rtl/bsw_pkg.sv =====
package bsw_pkg;

   localparam int ADDR_BITS = 13;
   localparam int ROM_DEPTH = 8192;
   localparam int RAM_DEPTH = 64;
   localparam int RAM_IDX_BITS = 6;
   localparam int SWITCH_DELAY = 3;

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_LOAD  = 2'd2;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_VREAD  = 2'd1,
      KIND_VWRITE = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_RAM_RD,
      OP_ROM_RD,
      OP_RAM_WR,
      OP_ROM_WR
   } op_type;

   typedef struct packed {
      op_type                 op;
      kind_type               kind;
      logic [ADDR_BITS-1:0]   addr;
      logic [7:0]             data;
      logic [3:0]             bank;
   } task_type;

   function automatic logic [2:0] slice_of(input logic [2:0] bank, input logic [1:0] quarter);
      logic [11:0] row;
      unique case (bank)
         3'd0:    row = {3'd3, 3'd1, 3'd0, 3'd0};
         3'd1:    row = {3'd3, 3'd2, 3'd1, 3'd0};
         3'd2:    row = {3'd7, 3'd6, 3'd5, 3'd4};
         3'd3:    row = {3'd3, 3'd2, 3'd4, 3'd7};
         3'd4:    row = {3'd7, 3'd6, 3'd0, 3'd0};
         3'd5:    row = {3'd6, 3'd7, 3'd1, 3'd0};
         3'd6:    row = {3'd5, 3'd4, 3'd3, 3'd2};
         default: row = {3'd1, 3'd5, 3'd0, 3'd6};
      endcase
      return row[quarter*3 +: 3];
   endfunction

endpackage

// ===== rtl/bsw_req_if.sv =====
interface bsw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [12:0] bus_address;
   logic [7:0]  write_byte;
   logic [31:0] cycle_now;

   modport source (output valid, cmd, bus_address, write_byte, cycle_now, input ready);
   modport sink (input valid, cmd, bus_address, write_byte, cycle_now, output ready);
endinterface

// ===== rtl/bsw_rsp_if.sv =====
interface bsw_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] read_byte;
   logic [3:0] active_bank;

   modport source (output valid, result_kind, read_byte, active_bank, input ready);
   modport sink (input valid, result_kind, read_byte, active_bank, output ready);
endinterface

// ===== rtl/delayed_bank_switch_cartridge.sv =====
// Requests pass a 2-entry queue, then the back stage registers each result.
// Throughput: one request per cycle unless the queue is full; the front stage
// updates bank state, the back one ROM/RAM access per cycle unless the output
// stalls. Reset clears bank, pending switch, queue and output; scratch RAM reads
// as zero until written (per-entry valid bits). ROM is undefined until loaded.
module delayed_bank_switch_cartridge #(
   parameter int CYCLE_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   bsw_req_if.sink   req_if,
   bsw_rsp_if.source rsp_if
);
   import bsw_pkg::*;

   task_type push_data;
   task_type pop_data;
   logic     push;
   logic     pop;
   logic     full;
   logic     empty;

   bsw_front #(
      .CYCLE_BITS (CYCLE_BITS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_if),
      .q_full (full),
      .q_push (push),
      .q_data (push_data)
   );

   bsw_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   bsw_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (empty),
      .q_data  (pop_data),
      .q_pop   (pop),
      .rsp     (rsp_if)
   );

endmodule

// ===== rtl/bsw_front.sv =====
module bsw_front #(
   parameter int CYCLE_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   bsw_req_if.sink             req,
   input  logic                q_full,
   output logic                q_push,
   output bsw_pkg::task_type   q_data
);
   import bsw_pkg::*;

   localparam int NOW_BITS = (CYCLE_BITS < 32) ? CYCLE_BITS : 32;

   logic [3:0]            cur_bank_ff, cur_bank_in;
   logic                  pend_ff, pend_in;
   logic [3:0]            pend_bank_ff, pend_bank_in;
   logic [CYCLE_BITS-1:0] stamp_ff, stamp_in;
   logic [CYCLE_BITS-1:0] now_c;
   logic [CYCLE_BITS-1:0] limit_c;
   logic                  accept;
   logic                  hot;
   logic [3:0]            bank_c;
   logic [2:0]            slice_c;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;
   assign q_push    = accept;

   assign now_c   = CYCLE_BITS'(req.cycle_now[NOW_BITS-1:0]);
   assign limit_c = stamp_ff + CYCLE_BITS'(SWITCH_DELAY);
   assign hot     = !req.bus_address[12] && (req.bus_address[7:4] == 4'h3);

   always_comb begin
      cur_bank_in  = cur_bank_ff;
      pend_in      = pend_ff;
      pend_bank_in = pend_bank_ff;
      stamp_in     = stamp_ff;
      if (req.cmd == CMD_READ) begin
         if (pend_ff && (now_c > limit_c)) begin
            cur_bank_in = pend_bank_ff;
            pend_in     = 1'b0;
         end
         if (hot) begin
            stamp_in     = now_c;
            pend_bank_in = req.bus_address[3:0];
            pend_in      = 1'b1;
         end
      end
   end

   assign bank_c  = cur_bank_in;
   assign slice_c = slice_of(bank_c[2:0], req.bus_address[11:10]);

   always_comb begin
      q_data.op   = OP_NONE;
      q_data.kind = KIND_NONE;
      q_data.addr = req.bus_address;
      q_data.data = req.write_byte;
      q_data.bank = bank_c;
      unique case (req.cmd)
         CMD_READ: begin
            if (!req.bus_address[12]) begin
               q_data.kind = KIND_VREAD;
            end else if (req.bus_address[11:6] == 6'd0) begin
               q_data.kind = KIND_DATA;
               q_data.op   = OP_RAM_RD;
            end else begin
               q_data.kind = KIND_DATA;
               q_data.op   = OP_ROM_RD;
               q_data.addr = {slice_c, req.bus_address[9:0]};
            end
         end
         CMD_WRITE: begin
            if (req.bus_address[12]) begin
               if (req.bus_address[11:7] == 5'd0) begin
                  q_data.op = OP_RAM_WR;
               end
            end else if (req.bus_address[11:6] == 6'd0) begin
               q_data.kind = KIND_VWRITE;
            end
         end
         CMD_LOAD: begin
            q_data.op = OP_ROM_WR;
         end
         default: begin
            q_data.op = OP_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_bank_ff  <= '0;
         pend_ff      <= 1'b0;
         pend_bank_ff <= '0;
         stamp_ff     <= '0;
      end else if (accept) begin
         cur_bank_ff  <= cur_bank_in;
         pend_ff      <= pend_in;
         pend_bank_ff <= pend_bank_in;
         stamp_ff     <= stamp_in;
      end
   end

endmodule

// ===== rtl/bsw_fifo.sv =====
module bsw_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bsw_pkg::task_type   push_data,
   output logic                full,
   input  logic                pop,
   output bsw_pkg::task_type   pop_data,
   output logic                empty
);
   import bsw_pkg::*;

   task_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_pop   = pop && !empty;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         unique case ({push, do_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== rtl/bsw_back.sv =====
module bsw_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  bsw_pkg::task_type   q_data,
   output logic                q_pop,
   bsw_rsp_if.source           rsp
);
   import bsw_pkg::*;

   logic [7:0]              rom_mem [ROM_DEPTH];
   logic [7:0]              ram_mem [RAM_DEPTH];
   logic [RAM_DEPTH-1:0]    ram_valid_ff;
   logic [RAM_IDX_BITS-1:0] ram_idx;
   logic                    issue;

   logic                    out_valid_ff;
   kind_type                kind_ff;
   logic [3:0]              bank_ff;
   logic                    sel_rom_ff;
   logic                    sel_ram_ff;
   logic                    ram_ok_ff;
   logic [7:0]              rom_q_ff;
   logic [7:0]              ram_q_ff;

   assign issue   = !q_empty && (!out_valid_ff || rsp.ready);
   assign q_pop   = issue;
   assign ram_idx = q_data.addr[RAM_IDX_BITS-1:0];

   always_ff @(posedge clock) begin
      if (issue && (q_data.op == OP_ROM_WR)) begin
         rom_mem[q_data.addr] <= q_data.data;
      end
      if (issue) begin
         rom_q_ff <= rom_mem[q_data.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (issue && (q_data.op == OP_RAM_WR)) begin
         ram_mem[ram_idx] <= q_data.data;
      end
      if (issue) begin
         ram_q_ff <= ram_mem[ram_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_valid_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (issue && (q_data.op == OP_RAM_WR)) begin
            ram_valid_ff[ram_idx] <= 1'b1;
         end
         if (issue) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         kind_ff    <= q_data.kind;
         bank_ff    <= q_data.bank;
         sel_rom_ff <= (q_data.op == OP_ROM_RD);
         sel_ram_ff <= (q_data.op == OP_RAM_RD);
         ram_ok_ff  <= ram_valid_ff[ram_idx];
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.result_kind = kind_ff;
   assign rsp.active_bank = bank_ff;

   always_comb begin
      priority if (sel_rom_ff) begin
         rsp.read_byte = rom_q_ff;
      end else if (sel_ram_ff && ram_ok_ff) begin
         rsp.read_byte = ram_q_ff;
      end else begin
         rsp.read_byte = 8'd0;
      end
   end

endmodule
